// File: rtl/rbst_pkg.sv
// Shared types and constants for the ray against box slab test.
// No dependencies; rbst_ifs, the core and the bench use it by scoped names.
`timescale 1ns / 1ps

package rbst_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } cfg_reg_e;

  localparam int unsigned NUM_AXES = 3;

  typedef struct packed {
    logic [NUM_AXES-1:0] zero_dir;
    logic                all_in;
  } side_t;

endpackage

// File: rtl/rbst_ifs.sv
// Channel interfaces of the slab test: ray input, hit result and box writes.
// Depends on rbst_pkg for the register index width.
`timescale 1ns / 1ps

interface rbst_ray_if #(parameter int unsigned W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] origin_x;
  logic [W-1:0] origin_y;
  logic [W-1:0] origin_z;
  logic [W-1:0] dir_x;
  logic [W-1:0] dir_y;
  logic [W-1:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rbst_hit_if #(parameter int unsigned W = 32);
  logic         valid;
  logic         ready;
  logic         hit;
  logic [W-1:0] t_entry;
  logic [W-1:0] t_exit;
  modport source (output valid, hit, t_entry, t_exit, input ready);
  modport sink (input valid, hit, t_entry, t_exit, output ready);
endinterface

interface rbst_cfg_if #(parameter int unsigned W = 32);
  logic                           valid;
  logic                           ready;
  logic [rbst_pkg::CFG_IDX_W-1:0] index;
  logic [W-1:0]                   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/rbst_div_lane.sv
// Pipelined restoring divider lane: (mag << F) / dm, one quotient bit per stage,
// saturated to the signed coordinate range and given the sign. No dependencies.
`timescale 1ns / 1ps

module rbst_div_lane #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W:0]   mag_i,
  input  logic [W-1:0] dm_i,
  input  logic         neg_i,
  output logic [W-1:0] quot_o
);

  localparam int unsigned NW = W + 1 + F;
  localparam int unsigned HW = F + 1;
  localparam int unsigned CW = (HW > W) ? HW : W;
  localparam logic [W-1:0] POS_LIM = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_LIM = {1'b1, {(W-1){1'b0}}};

  logic [NW-1:0] num;
  logic [HW-1:0] num_hi;
  logic [CW-1:0] hi_ext;
  logic          ovf;

  logic [W-1:0] r_q   [0:W];
  logic [W-1:0] q_q   [0:W];
  logic [W-1:0] n_q   [0:W];
  logic [W-1:0] dm_q  [0:W];
  logic         neg_q [0:W];
  logic         ovf_q [0:W];

  assign num    = NW'(mag_i) << F;
  assign num_hi = num[NW-1:W];
  assign hi_ext = CW'(num_hi);
  assign ovf    = hi_ext >= CW'(dm_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= hi_ext[W-1:0];
      q_q[0]   <= '0;
      n_q[0]   <= num[W-1:0];
      dm_q[0]  <= dm_i;
      neg_q[0] <= neg_i;
      ovf_q[0] <= ovf;
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_step
    logic [W:0]   rs;
    logic         ge;
    logic [W:0]   rn;
    assign rs = {r_q[s-1], n_q[s-1][W-s]};
    assign ge = rs >= {1'b0, dm_q[s-1]};
    assign rn = ge ? (rs - {1'b0, dm_q[s-1]}) : rs;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]   <= rn[W-1:0];
        q_q[s]   <= q_q[s-1] | (W'(ge) << (W-s));
        n_q[s]   <= n_q[s-1];
        dm_q[s]  <= dm_q[s-1];
        neg_q[s] <= neg_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  logic [W-1:0] lim;
  logic [W-1:0] qs;
  logic [W-1:0] quot_q;

  assign lim = neg_q[W] ? NEG_LIM : POS_LIM;
  assign qs  = (ovf_q[W] || (q_q[W] > lim)) ? lim : q_q[W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= neg_q[W] ? (W'(0) - qs) : qs;
    end
  end

  assign quot_o = quot_q;

endmodule

// File: rtl/ray_box_slab_test_core.sv
// Ray against axis-aligned box by the slab method, signed fixed point.
// The pipeline runs through the one-bit-per-stage divider lanes, six of them
// working in parallel.
// Throughput: one ray per cycle; the whole pipeline holds while a result stalls.
// Reset: rst_ni clears all valid bits and the box corners to zero.
// Depends on rbst_pkg, rbst_ifs and rbst_div_lane.
`timescale 1ns / 1ps

module ray_box_slab_test_core #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rbst_cfg_if.sink    cfg_i,
  rbst_ray_if.sink    ray_i,
  rbst_hit_if.source  hit_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned LDLY = W + 2;
  localparam int unsigned LAT  = W + 5;
  localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};

  logic [W-1:0] box_lo_q [0:2];
  logic [W-1:0] box_hi_q [0:2];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        box_lo_q[a] <= '0;
        box_hi_q[a] <= '0;
      end
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rbst_pkg::REG_BOX_MIN_X: box_lo_q[0] <= cfg_i.data;
        rbst_pkg::REG_BOX_MIN_Y: box_lo_q[1] <= cfg_i.data;
        rbst_pkg::REG_BOX_MIN_Z: box_lo_q[2] <= cfg_i.data;
        rbst_pkg::REG_BOX_MAX_X: box_hi_q[0] <= cfg_i.data;
        rbst_pkg::REG_BOX_MAX_Y: box_hi_q[1] <= cfg_i.data;
        rbst_pkg::REG_BOX_MAX_Z: box_hi_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic adv;
  logic vld_q [0:LAT-1];
  logic out_hit_q;

  assign adv         = !vld_q[LAT-1] || hit_o.ready;
  assign ray_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LAT; s++) vld_q[s] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= ray_i.valid;
      for (int s = 1; s < LAT; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  logic [W-1:0] org [0:2];
  logic [W-1:0] dir [0:2];

  assign org[0] = ray_i.origin_x;
  assign org[1] = ray_i.origin_y;
  assign org[2] = ray_i.origin_z;
  assign dir[0] = ray_i.dir_x;
  assign dir[1] = ray_i.dir_y;
  assign dir[2] = ray_i.dir_z;

  logic [W:0]    mag_d [0:5];
  logic          neg_d [0:5];
  logic [W-1:0]  dm_d  [0:2];
  rbst_pkg::side_t side_d;

  always_comb begin
    logic signed [W:0] df;
    side_d.all_in = 1'b1;
    for (int a = 0; a < 3; a++) begin
      dm_d[a] = dir[a][W-1] ? (W'(0) - dir[a]) : dir[a];
      side_d.zero_dir[a] = (dir[a] == '0);
      for (int k = 0; k < 2; k++) begin
        df = $signed({(k == 0) ? box_lo_q[a][W-1] : box_hi_q[a][W-1],
                      (k == 0) ? box_lo_q[a] : box_hi_q[a]})
           - $signed({org[a][W-1], org[a]});
        mag_d[2*a+k] = df[W] ? ((W+1)'(0) - df) : df;
        neg_d[2*a+k] = df[W] ^ dir[a][W-1];
      end
      if (side_d.zero_dir[a] &&
          ($signed(org[a]) < $signed(box_lo_q[a]) ||
           $signed(org[a]) > $signed(box_hi_q[a]))) begin
        side_d.all_in = 1'b0;
      end
    end
  end

  logic [W:0]      mag_q [0:5];
  logic            neg_q [0:5];
  logic [W-1:0]    dm_q  [0:2];
  rbst_pkg::side_t side_q [0:LDLY];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 6; l++) begin
        mag_q[l] <= mag_d[l];
        neg_q[l] <= neg_d[l];
      end
      for (int a = 0; a < 3; a++) dm_q[a] <= dm_d[a];
      side_q[0] <= side_d;
      for (int s = 1; s <= LDLY; s++) side_q[s] <= side_q[s-1];
    end
  end

  logic [W-1:0] tq [0:5];

  for (genvar l = 0; l < 6; l++) begin : g_lane
    rbst_div_lane #(.W(W), .F(FRAC_BITS)) u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .mag_i  (mag_q[l]),
      .dm_i   (dm_q[l/2]),
      .neg_i  (neg_q[l]),
      .quot_o (tq[l])
    );
  end

  logic [W-1:0] lo_q [0:2];
  logic [W-1:0] hi_q [0:2];
  logic         all_in_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      all_in_q <= side_q[LDLY].all_in;
      for (int a = 0; a < 3; a++) begin
        if (side_q[LDLY].zero_dir[a]) begin
          lo_q[a] <= '0;
          hi_q[a] <= POS_MAX;
        end else if ($signed(tq[2*a]) > $signed(tq[2*a+1])) begin
          lo_q[a] <= tq[2*a+1];
          hi_q[a] <= tq[2*a];
        end else begin
          lo_q[a] <= tq[2*a];
          hi_q[a] <= tq[2*a+1];
        end
      end
    end
  end

  logic [W-1:0] tn;
  logic [W-1:0] tf;
  logic         hit_d;
  logic [W-1:0] out_tn_q;
  logic [W-1:0] out_tf_q;

  always_comb begin
    tn = '0;
    tf = POS_MAX;
    for (int a = 0; a < 3; a++) begin
      if ($signed(lo_q[a]) > $signed(tn)) tn = lo_q[a];
      if ($signed(hi_q[a]) < $signed(tf)) tf = hi_q[a];
    end
    hit_d = all_in_q && ($signed(tn) <= $signed(tf)) && !tf[W-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_hit_q <= hit_d;
      out_tn_q  <= hit_d ? tn : '0;
      out_tf_q  <= hit_d ? tf : '0;
    end
  end

  assign hit_o.valid   = vld_q[LAT-1];
  assign hit_o.hit     = out_hit_q;
  assign hit_o.t_entry = out_tn_q;
  assign hit_o.t_exit  = out_tf_q;

endmodule

// File: rtl/rbst_checker.sv
// Port-level checks of the slab test core, attached by the bind at the end.
// Depends on the channel interfaces of ray_box_slab_test_core.
`timescale 1ns / 1ps

module rbst_checker #(
  parameter int unsigned W = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         cfg_ready,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic         out_hit,
  input logic [W-1:0] out_t_entry,
  input logic [W-1:0] out_t_exit
);

  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (out_valid && !out_ready))
    else $error("ray input stalled without a stalled result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hit) &&
                                   $stable(out_t_entry) && $stable(out_t_exit)))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_hit) |-> (out_t_entry == '0 && out_t_exit == '0))
    else $error("miss carries nonzero distances");

  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_hit) |-> (!out_t_entry[W-1] && !out_t_exit[W-1] &&
                                out_t_entry <= out_t_exit))
    else $error("hit with entry after exit or negative distance");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready)
    else $error("box write port not ready");

endmodule

bind ray_box_slab_test_core rbst_checker #(.W(COORD_WIDTH)) u_rbst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_ready   (cfg_i.ready),
  .in_ready    (ray_i.ready),
  .out_valid   (hit_o.valid),
  .out_ready   (hit_o.ready),
  .out_hit     (hit_o.hit),
  .out_t_entry (hit_o.t_entry),
  .out_t_exit  (hit_o.t_exit)
);

// File: bench/tb.sv
// Self-checking bench for the ray against box slab test core.
// Drives rays and box writes through the rbst interfaces, predicts each result
// with its own fixed-point slab model and compares every field. Needs rbst_pkg, rbst_ifs and the core.
`timescale 1ns / 1ps

module tb;

  localparam int W = 32;
  localparam int FB = 16;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int NUM_BLOCKS = 10;
  localparam int RAYS_PER_BLOCK = 145;
  localparam int unsigned PHASE_LEN = 480;
  localparam int BOX_SPREAD = 1 << 20;
  localparam int ORG_SPREAD = 1 << 21;
  localparam int DIR_SPREAD = 1 << 17;
  localparam logic [rbst_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  typedef struct packed {
    logic [W-1:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct packed {
    logic         hit;
    logic [W-1:0] t_entry;
    logic [W-1:0] t_exit;
  } hit_t;

  typedef enum logic [1:0] {
    CMD_RAY,
    CMD_CFG,
    CMD_WAIT
  } cmd_e;

  typedef struct {
    cmd_e                            kind;
    logic [rbst_pkg::CFG_IDX_W-1:0]  idx;
    logic [W-1:0]                    data;
    ray_t                            ray;
  } cmd_t;

  logic clk_i;
  logic rst_ni;

  rbst_ray_if #(W) ray_ch ();
  rbst_hit_if #(W) hit_ch ();
  rbst_cfg_if #(W) cfg_ch ();

  ray_box_slab_test_core #(.COORD_WIDTH(W), .FRAC_BITS(FB)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .ray_i (ray_ch),
    .hit_o (hit_ch)
  );

  cmd_t   cmd_queue[$];
  hit_t   expected_hits[$];
  logic signed [W-1:0] box_lo[3];
  logic signed [W-1:0] box_hi[3];
  int     errors = 0;
  longint cycles = 0;
  int     unsigned rays_sent = 0;
  logic   ray_taken_q;
  logic   cfg_taken_q;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report(input string what, input logic [W-1:0] got, input logic [W-1:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic int send_idle(input int unsigned n);
    if (n < PHASE_LEN) return 29;
    if (n < 2 * PHASE_LEN) return 87;
    return 0;
  endfunction

  function automatic int recv_idle(input int unsigned n);
    if (n < PHASE_LEN) return 87;
    if (n < 2 * PHASE_LEN) return 29;
    return 0;
  endfunction

  // Plane distance (plane - org) * 2^FB / dir, truncated toward zero, saturated.
  function automatic logic signed [W-1:0] plane_dist(
      input logic signed [W-1:0] plane, input logic signed [W-1:0] org,
      input logic signed [W-1:0] dir);
    logic signed [W+FB+1:0] num;
    logic signed [W+FB+1:0] den;
    logic signed [W+FB+1:0] quo;
    num = (W+FB+2)'(plane) - (W+FB+2)'(org);
    num = num <<< FB;
    den = (W+FB+2)'(dir);
    quo = num / den;
    if (quo > $signed({{(FB+3){1'b0}}, {(W-1){1'b1}}}))
      return {1'b0, {(W-1){1'b1}}};
    if (quo < $signed({{(FB+3){1'b1}}, {(W-1){1'b0}}}))
      return {1'b1, {(W-1){1'b0}}};
    return quo[W-1:0];
  endfunction

  function automatic hit_t predict_hit(input ray_t r);
    logic signed [W-1:0] org[3];
    logic signed [W-1:0] dir[3];
    logic signed [W-1:0] near_t;
    logic signed [W-1:0] far_t;
    logic signed [W-1:0] t1;
    logic signed [W-1:0] t2;
    logic signed [W-1:0] tmp;
    logic ok;
    hit_t res;
    org = '{r.ox, r.oy, r.oz};
    dir = '{r.dx, r.dy, r.dz};
    near_t = '0;
    far_t = {1'b0, {(W-1){1'b1}}};
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (ok) begin
        if (dir[a] == 0) begin
          ok = !(org[a] < box_lo[a] || org[a] > box_hi[a]);
        end else begin
          t1 = plane_dist(box_lo[a], org[a], dir[a]);
          t2 = plane_dist(box_hi[a], org[a], dir[a]);
          if (t1 > t2) begin
            tmp = t1; t1 = t2; t2 = tmp;
          end
          if (t1 > near_t) near_t = t1;
          if (t2 < far_t) far_t = t2;
          if (near_t > far_t || far_t < 0) ok = 1'b0;
        end
      end
    end
    res.hit = ok;
    res.t_entry = ok ? near_t : '0;
    res.t_exit = ok ? far_t : '0;
    return res;
  endfunction

  function automatic logic [W-1:0] pick_coord(input int spread);
    int unsigned sel;
    int v;
    sel = $urandom_range(0, 15);
    v = int'($urandom_range(0, 2 * spread)) - spread;
    if (sel == 0) return '0;
    if (sel == 1) return W'($urandom);
    if (sel == 2) return {1'b1, {(W-1){1'b0}}};
    if (sel == 3) return {1'b0, {(W-1){1'b1}}};
    if (sel == 4) return W'(int'($urandom_range(0, 4)) - 2);
    return W'(v);
  endfunction

  function automatic logic [W-1:0] pick_dir();
    if ($urandom_range(0, 3) == 0) return '0;
    return pick_coord(DIR_SPREAD);
  endfunction

  function automatic ray_t make_ray();
    ray_t r;
    r.ox = pick_coord(ORG_SPREAD);
    r.oy = pick_coord(ORG_SPREAD);
    r.oz = pick_coord(ORG_SPREAD);
    r.dx = pick_dir();
    r.dy = pick_dir();
    r.dz = pick_dir();
    return r;
  endfunction

  task automatic enqueue(input cmd_e kind, input logic [rbst_pkg::CFG_IDX_W-1:0] idx,
                         input logic [W-1:0] data, input ray_t ray);
    cmd_t c;
    c.kind = kind;
    c.idx  = idx;
    c.data = data;
    c.ray  = ray;
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  task automatic add_box_axis(input rbst_pkg::cfg_reg_e lo_idx,
                              input rbst_pkg::cfg_reg_e hi_idx);
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] t;
    a = pick_coord(BOX_SPREAD);
    b = pick_coord(BOX_SPREAD);
    if ($urandom_range(0, 4) != 0 && $signed(a) > $signed(b)) begin
      t = a; a = b; b = t;
    end
    enqueue(CMD_CFG, lo_idx, a, '0);
    enqueue(CMD_CFG, hi_idx, b, '0);
  endtask

  // Ray and box write driver; a box write or a pause waits until every result is back.
  always @(negedge clk_i or negedge rst_ni) begin : p_drive
    logic ray_busy;
    logic cfg_busy;
    logic take;
    cmd_t cmd;
    if (!rst_ni) begin
      ray_ch.valid <= 1'b0;
      {ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z} <= '0;
      {ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z} <= '0;
      cfg_ch.valid <= 1'b0;
      cfg_ch.index <= '0;
      cfg_ch.data <= '0;
    end else begin
      ray_busy = ray_ch.valid && !ray_taken_q;
      cfg_busy = cfg_ch.valid && !cfg_taken_q;
      if (!ray_busy && !cfg_busy) begin
        take = 1'b0;
        cmd.kind = CMD_WAIT;
        if (cmd_queue.size() != 0 &&
            int'($urandom_range(0, 99)) >= send_idle(rays_sent)) begin
          cmd = cmd_queue[0];
          if (cmd.kind == CMD_RAY) take = 1'b1;
          else take = (expected_hits.size() == 0);
        end
        ray_ch.valid <= take && (cmd.kind == CMD_RAY);
        cfg_ch.valid <= take && (cmd.kind == CMD_CFG);
        if (take && cmd.kind == CMD_RAY) begin
          {ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z,
           ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z} <= cmd.ray;
        end
        if (take && cmd.kind == CMD_CFG) begin
          cfg_ch.index <= cmd.idx;
          cfg_ch.data <= cmd.data;
        end
        if (take) void'(cmd_queue.pop_front());
      end
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hit_ch.ready <= 1'b0;
    else hit_ch.ready <= (int'($urandom_range(0, 99)) >= recv_idle(rays_sent));
  end

  // Monitor: checks each result transfer, predicts each ray transfer and tracks box writes.
  always @(posedge clk_i) begin : p_monitor
    hit_t want;
    hit_t got;
    if (!rst_ni) begin
      ray_taken_q <= 1'b0;
      cfg_taken_q <= 1'b0;
    end else begin
      ray_taken_q <= ray_ch.valid && ray_ch.ready;
      cfg_taken_q <= cfg_ch.valid && cfg_ch.ready;
      if (hit_ch.valid && hit_ch.ready) begin
        got = {hit_ch.hit, hit_ch.t_entry, hit_ch.t_exit};
        if (expected_hits.size() == 0) begin
          report("unexpected result", got.t_entry, '0);
        end else begin
          want = expected_hits.pop_front();
          if (got.hit != want.hit) report("hit", W'(got.hit), W'(want.hit));
          if (got.t_entry != want.t_entry) report("t_entry", got.t_entry, want.t_entry);
          if (got.t_exit != want.t_exit) report("t_exit", got.t_exit, want.t_exit);
        end
      end
      if (ray_ch.valid && ray_ch.ready) begin
        expected_hits.insert(expected_hits.size(),
                             predict_hit({ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z,
                                          ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z}));
        rays_sent++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          rbst_pkg::REG_BOX_MIN_X: box_lo[0] = cfg_ch.data;
          rbst_pkg::REG_BOX_MIN_Y: box_lo[1] = cfg_ch.data;
          rbst_pkg::REG_BOX_MIN_Z: box_lo[2] = cfg_ch.data;
          rbst_pkg::REG_BOX_MAX_X: box_hi[0] = cfg_ch.data;
          rbst_pkg::REG_BOX_MAX_Y: box_hi[1] = cfg_ch.data;
          rbst_pkg::REG_BOX_MAX_Z: box_hi[2] = cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  initial begin : p_stim
    rst_ni = 1'b0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = '0;
      box_hi[a] = '0;
    end
    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      if (blk != 0) begin
        add_box_axis(rbst_pkg::REG_BOX_MIN_X, rbst_pkg::REG_BOX_MAX_X);
        add_box_axis(rbst_pkg::REG_BOX_MIN_Y, rbst_pkg::REG_BOX_MAX_Y);
        add_box_axis(rbst_pkg::REG_BOX_MIN_Z, rbst_pkg::REG_BOX_MAX_Z);
      end
      if (blk == 5) enqueue(CMD_CFG, CFG_IDX_UNUSED, W'($urandom), '0);
      for (int r = 0; r < RAYS_PER_BLOCK; r++) enqueue(CMD_RAY, '0, '0, make_ray());
      if (blk == 3 || blk == 6) enqueue(CMD_WAIT, '0, '0, '0);
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    do begin
      @(posedge clk_i);
    end while (cmd_queue.size() != 0 || expected_hits.size() != 0 ||
               ray_ch.valid || cfg_ch.valid);
    repeat (5) @(posedge clk_i);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
